### rtl/dad_pkg.sv
package dad_pkg;

  // Field widths of one transaction
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned STATUS_W = 2;

  // Packed stream widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 24;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_YEAR = 2'd1;

  localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 12'd1920;
  localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 12'd2029;

  // Calendar constants
  localparam logic [MONTH_W-1:0] FIRST_MONTH = 4'd1;
  localparam logic [MONTH_W-1:0] LAST_MONTH  = 4'd12;
  localparam logic [DAY_W-1:0]   FIRST_DAY   = 5'd1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_YEAR  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_MONTH = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_DAY   = 2'd3;

  // Control from the top level into the month walker
  typedef struct packed {
    logic start;  // load a new transaction
    logic take;   // finished result moved to the output register
  } dad_ctl_t;

  // Status from the month walker
  typedef struct packed {
    logic idle;   // ready for a new transaction
    logic done;   // result valid, waiting to be taken
  } dad_sts_t;

  // Month length, no leap years; zero for codes that are no month
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month);
    logic [DAY_W-1:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

### rtl/dad_walk.sv
module dad_walk #(
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dad_pkg::dad_ctl_t              ctl,
  output dad_pkg::dad_sts_t              sts,
  input  logic [dad_pkg::DAY_W-1:0]      ld_day,
  input  logic [dad_pkg::MONTH_W-1:0]    ld_month,
  input  logic [dad_pkg::YEAR_W-1:0]     ld_year,
  input  logic [COUNT_BITS-1:0]          ld_count,
  input  logic [dad_pkg::STATUS_W-1:0]   ld_status,
  output logic [dad_pkg::DAY_W-1:0]      res_day,
  output logic [dad_pkg::MONTH_W-1:0]    res_month,
  output logic [dad_pkg::YEAR_W-1:0]     res_year,
  output logic [dad_pkg::STATUS_W-1:0]   res_status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                     state_r, state_nxt;
  logic [dad_pkg::DAY_W-1:0]      day_r, day_nxt;
  logic [dad_pkg::MONTH_W-1:0]    month_r, month_nxt;
  logic [dad_pkg::YEAR_W-1:0]     year_r, year_nxt;
  logic [COUNT_BITS-1:0]          left_r, left_nxt;
  logic [dad_pkg::STATUS_W-1:0]   status_r, status_nxt;

  logic [dad_pkg::DAY_W-1:0]      rest;
  logic [COUNT_BITS-1:0]          rest_ext;
  logic                           fits;

  // Days left in the current month after the current day
  assign rest     = dad_pkg::month_len(month_r) - day_r;
  assign rest_ext = {{(COUNT_BITS - dad_pkg::DAY_W){1'b0}}, rest};
  assign fits     = (left_r <= rest_ext);

  // Sequencer: load, step one month per cycle, hold the result
  always_comb begin
    state_nxt  = state_r;
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    left_nxt   = left_r;
    status_nxt = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          status_nxt = ld_status;
          left_nxt   = ld_count;
          if (ld_status == dad_pkg::ST_OK) begin
            day_nxt   = ld_day;
            month_nxt = ld_month;
            year_nxt  = ld_year;
            state_nxt = S_RUN;
          end else begin
            day_nxt   = '0;
            month_nxt = '0;
            year_nxt  = '0;
            state_nxt = S_DONE;
          end
        end
      end
      S_RUN: begin
        if (fits) begin
          day_nxt   = day_r + left_r[dad_pkg::DAY_W-1:0];
          state_nxt = S_DONE;
        end else begin
          left_nxt = left_r - rest_ext - {{(COUNT_BITS-1){1'b0}}, 1'b1};
          day_nxt  = dad_pkg::FIRST_DAY;
          if (month_r == dad_pkg::LAST_MONTH) begin
            month_nxt = dad_pkg::FIRST_MONTH;
            year_nxt  = year_r + {{(dad_pkg::YEAR_W-1){1'b0}}, 1'b1};
          end else begin
            month_nxt = month_r + {{(dad_pkg::MONTH_W-1){1'b0}}, 1'b1};
          end
        end
      end
      S_DONE: begin
        if (ctl.take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    day_r    <= day_nxt;
    month_r  <= month_nxt;
    year_r   <= year_nxt;
    left_r   <= left_nxt;
    status_r <= status_nxt;
  end

  assign sts.idle   = (state_r == S_IDLE);
  assign sts.done   = (state_r == S_DONE);
  assign res_day    = day_r;
  assign res_month  = month_r;
  assign res_year   = year_r;
  assign res_status = status_r;

endmodule

### rtl/date_add_days_unit.sv
// Channel   Direction  Ports                        Contents
// in_       slave      tvalid, tready, tdata[39:0]  start date and day count
// out_      master     tvalid, tready, tdata[23:0]  end date and status
// cfg_      write      wr_en, index[1:0], wdata     min_year (0), max_year (1)
//
// A transaction is loaded, then the walker crosses one month boundary per step
// until the day count left fits in the current month, takes a final step and
// passes the result to the output register. The month walker steps one month
// per cycle. A bad start date skips the walk. Reset is synchronous, active low;
// it sets min_year to 1920 and max_year to 2029. While out_tready is low the
// result holds in the output register and the walker holds its next result.
module date_add_days_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // start_day [4:0], start_month [8:5], start_year [20:9], day_count [36:21]
  input  logic [dad_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // end_day [4:0], end_month [8:5], end_year [20:9], status [22:21]
  output logic [dad_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [dad_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dad_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [dad_pkg::YEAR_W-1:0]     min_year_r;
  logic [dad_pkg::YEAR_W-1:0]     max_year_r;

  logic [dad_pkg::DAY_W-1:0]      in_day;
  logic [dad_pkg::MONTH_W-1:0]    in_month;
  logic [dad_pkg::YEAR_W-1:0]     in_year;
  logic [dad_pkg::COUNT_W-1:0]    in_count;
  logic [COUNT_BITS-1:0]          in_left;
  logic [dad_pkg::STATUS_W-1:0]   in_status;

  dad_pkg::dad_ctl_t              ctl;
  dad_pkg::dad_sts_t              sts;

  logic [dad_pkg::DAY_W-1:0]      res_day;
  logic [dad_pkg::MONTH_W-1:0]    res_month;
  logic [dad_pkg::YEAR_W-1:0]     res_year;
  logic [dad_pkg::STATUS_W-1:0]   res_status;

  logic                           out_tvalid_r;
  logic [dad_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic                           out_load;

  // Unpack the input transaction
  assign in_day   = in_tdata[4:0];
  assign in_month = in_tdata[8:5];
  assign in_year  = in_tdata[20:9];
  assign in_count = in_tdata[36:21];

  // Fit the day count to COUNT_BITS bits: zero-extend it, or keep its low bits
  generate
    if (COUNT_BITS >= dad_pkg::COUNT_W) begin : g_count_ext
      assign in_left = {{(COUNT_BITS - dad_pkg::COUNT_W){1'b0}}, in_count};
    end else begin : g_count_cut
      assign in_left = in_count[COUNT_BITS-1:0];
    end
  endgenerate

  // Check the start date: year, then month, then day
  always_comb begin
    if (in_year < min_year_r || in_year > max_year_r) begin
      in_status = dad_pkg::ST_BAD_YEAR;
    end else if (in_month < dad_pkg::FIRST_MONTH || in_month > dad_pkg::LAST_MONTH) begin
      in_status = dad_pkg::ST_BAD_MONTH;
    end else if (in_day == '0 || in_day > dad_pkg::month_len(in_month)) begin
      in_status = dad_pkg::ST_BAD_DAY;
    end else begin
      in_status = dad_pkg::ST_OK;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_year_r <= dad_pkg::MIN_YEAR_RST;
      max_year_r <= dad_pkg::MAX_YEAR_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == dad_pkg::CFG_MIN_YEAR) begin
        min_year_r <= cfg_wdata[dad_pkg::YEAR_W-1:0];
      end else if (cfg_index == dad_pkg::CFG_MAX_YEAR) begin
        max_year_r <= cfg_wdata[dad_pkg::YEAR_W-1:0];
      end
    end
  end

  assign in_tready = sts.idle;
  assign out_load  = sts.done && (!out_tvalid_r || out_tready);
  assign ctl.start = in_tvalid && in_tready;
  assign ctl.take  = out_load;

  dad_walk #(
    .COUNT_BITS (COUNT_BITS)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .ld_day     (in_day),
    .ld_month   (in_month),
    .ld_year    (in_year),
    .ld_count   (in_left),
    .ld_status  (in_status),
    .res_day    (res_day),
    .res_month  (res_month),
    .res_year   (res_year),
    .res_status (res_status)
  );

  // Output register: load a finished result, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {1'b0, res_status, res_year, res_month, res_day};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
